>>> hdl/iqbr_pkg.sv
// shared constants, types and helpers for the iq byte linear resampler
`default_nettype none

package iqbr_pkg;

    // sample and result widths
    localparam int BYTE_BITS      = 8;
    localparam int OUT_BITS       = 19;
    localparam int FRAC_BITS      = 11;
    localparam int POS_BITS       = 14;
    localparam int OIDX_BITS      = 12;
    localparam int ACC_BITS       = 25;
    localparam int SKIP_BITS      = 24;

    // configuration port
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 24;

    // block geometry
    localparam logic [POS_BITS-1:0]  MIN_BLOCK_LEN   = 14'd2049;
    localparam logic [POS_BITS-1:0]  RESET_BLOCK_LEN = 14'd2500;
    localparam logic [SKIP_BITS-1:0] SKIP_STEP       = 24'd2048;
    localparam logic [OIDX_BITS-1:0] LAST_OUT_INDEX  = 12'd2047;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_BYPASS    = 2'd0,
        CFG_BLOCK_LEN = 2'd1,
        CFG_SKIP      = 2'd2
    } cfg_reg_t;

    // operands of one interpolation, handed from the state stage to the output stage
    typedef struct packed {
        logic [BYTE_BITS-1:0] prev_i;
        logic [BYTE_BITS-1:0] prev_q;
        logic [BYTE_BITS-1:0] cur_i;
        logic [BYTE_BITS-1:0] cur_q;
        logic [FRAC_BITS-1:0] frac;
        logic                 block_end;
    } interp_op_t;

    // offset binary byte to two's complement (byte minus 128)
    function automatic logic signed [BYTE_BITS-1:0] centered(
        input logic [BYTE_BITS-1:0] b
    );
        centered = $signed({~b[BYTE_BITS-1], b[BYTE_BITS-2:0]});
    endfunction

endpackage

`default_nettype wire

>>> hdl/iqbr_stream_if.sv
// valid/ready stream interfaces for input samples and interpolated results
`default_nettype none

interface iqbr_sample_if;
    logic                               valid;
    logic                               ready;
    logic [iqbr_pkg::BYTE_BITS-1:0]     in_i_byte;
    logic [iqbr_pkg::BYTE_BITS-1:0]     in_q_byte;

    modport source (output valid, output in_i_byte, output in_q_byte, input ready);
    modport sink   (input valid, input in_i_byte, input in_q_byte, output ready);
endinterface

interface iqbr_result_if;
    logic                               valid;
    logic                               ready;
    logic signed [iqbr_pkg::OUT_BITS-1:0] out_i;
    logic signed [iqbr_pkg::OUT_BITS-1:0] out_q;
    logic                               block_end;

    modport source (output valid, output out_i, output out_q, output block_end, input ready);
    modport sink   (input valid, input out_i, input out_q, input block_end, output ready);
endinterface

`default_nettype wire

>>> hdl/iq_byte_linear_resampler_top.sv
// Linear interpolation resampler for complex offset-binary byte samples.
// Channels: sample (sink) takes one i/q byte pair per transfer; result
// (source) gives interpolated i/q scaled by 2^11 plus a block end flag.
// In resample mode each block of input_block_len inputs maps onto 2048
// results; at most one result follows each input, none for the first input
// after a restart. In bypass mode every input gives one result, x*2048.
// An input transfer passes through the position/state stage register and
// then the interpolation multiplier stage register before result.valid.
// Throughput is one input per clock while sample.ready is high; the per-item
// state update (position compare and accumulator add) is combinational.
// A stalled receiver holds the result register; the state stage keeps
// taking inputs while its operand register is free, and sample.ready drops
// only once both stages hold a pending result.
// Reset clears all state but the payload registers, selects resample mode with a block length of 2500
// and zero skip; writes to mode or length restart the block alignment.
`default_nettype none

module iq_byte_linear_resampler_top
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [iqbr_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [iqbr_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    iqbr_sample_if.sink                               sample,
    iqbr_result_if.source                             result
);

    // configuration
    logic                              bypass_reg, bypass_next;
    logic [iqbr_pkg::POS_BITS-1:0]     len_reg, len_next;

    // resampler state
    logic                              have_first_reg, have_first_next;
    logic [iqbr_pkg::POS_BITS-1:0]     pos_reg, pos_next;
    logic [iqbr_pkg::OIDX_BITS-1:0]    oidx_reg, oidx_next;
    logic [iqbr_pkg::ACC_BITS-1:0]     acc_reg, acc_next;
    logic [iqbr_pkg::BYTE_BITS-1:0]    prev_i_reg, prev_i_next;
    logic [iqbr_pkg::BYTE_BITS-1:0]    prev_q_reg, prev_q_next;
    logic [iqbr_pkg::SKIP_BITS-1:0]    skip_left_reg, skip_left_next;
    logic                              muted_reg, muted_next;

    // stage between state logic and interpolation
    logic                              s1_valid_reg, s1_valid_next;
    iqbr_pkg::interp_op_t              s1_op_reg, s1_op_next;
    logic                              op_ready;

    logic                              in_xfer;
    logic                              hit;
    logic [iqbr_pkg::POS_BITS-1:0]     pos_inc;
    logic                              block_done;
    logic [iqbr_pkg::SKIP_BITS-1:0]    skip_after;
    logic [iqbr_pkg::POS_BITS-1:0]     len_wr;

    assign sample.ready = !s1_valid_reg || op_ready;
    assign in_xfer      = sample.valid && sample.ready;

    // pending output is due when its left neighbor is the current position
    assign hit        = (acc_reg[iqbr_pkg::ACC_BITS-1:iqbr_pkg::FRAC_BITS] == pos_reg);
    assign pos_inc    = pos_reg + 1'b1;
    assign block_done = (pos_inc >= len_reg);
    assign len_wr     = (cfg_data[iqbr_pkg::POS_BITS-1:0] < iqbr_pkg::MIN_BLOCK_LEN)
                        ? iqbr_pkg::MIN_BLOCK_LEN : cfg_data[iqbr_pkg::POS_BITS-1:0];

    // skip counter after a block end, saturating at zero
    always_comb
    begin
        skip_after = skip_left_reg;
        if (muted_reg)
        begin
            skip_after = (skip_left_reg > iqbr_pkg::SKIP_STEP)
                         ? skip_left_reg - iqbr_pkg::SKIP_STEP : '0;
        end
    end

    // next state for configuration writes and input transfers
    always_comb
    begin
        bypass_next     = bypass_reg;
        len_next        = len_reg;
        have_first_next = have_first_reg;
        pos_next        = pos_reg;
        oidx_next       = oidx_reg;
        acc_next        = acc_reg;
        prev_i_next     = prev_i_reg;
        prev_q_next     = prev_q_reg;
        skip_left_next  = skip_left_reg;
        muted_next      = muted_reg;
        s1_valid_next   = s1_valid_reg && !op_ready;
        s1_op_next      = s1_op_reg;

        if (cfg_we)
        begin
            unique case (iqbr_pkg::cfg_reg_t'(cfg_index))
                iqbr_pkg::CFG_BYPASS,
                iqbr_pkg::CFG_BLOCK_LEN:
                begin
                    if (iqbr_pkg::cfg_reg_t'(cfg_index) == iqbr_pkg::CFG_BYPASS)
                    begin
                        bypass_next = cfg_data[0];
                    end
                    else
                    begin
                        len_next = len_wr;
                    end
                    have_first_next = 1'b0;
                    pos_next        = '0;
                    oidx_next       = '0;
                    acc_next        = '0;
                    prev_i_next     = '0;
                    prev_q_next     = '0;
                    muted_next      = 1'b0;
                end
                iqbr_pkg::CFG_SKIP:
                begin
                    skip_left_next = cfg_data[iqbr_pkg::SKIP_BITS-1:0];
                end
                default:
                begin
                end
            endcase
        end
        else if (in_xfer)
        begin
            if (bypass_reg)
            begin
                // straight through: interpolation with a zero fraction
                s1_valid_next        = 1'b1;
                s1_op_next.prev_i    = sample.in_i_byte;
                s1_op_next.prev_q    = sample.in_q_byte;
                s1_op_next.cur_i     = sample.in_i_byte;
                s1_op_next.cur_q     = sample.in_q_byte;
                s1_op_next.frac      = '0;
                s1_op_next.block_end = 1'b0;
            end
            else if (!have_first_reg)
            begin
                // first sample of a fresh alignment starts block zero
                have_first_next = 1'b1;
                pos_next        = '0;
                oidx_next       = '0;
                acc_next        = '0;
                prev_i_next     = sample.in_i_byte;
                prev_q_next     = sample.in_q_byte;
                muted_next      = (skip_left_reg != '0);
            end
            else
            begin
                if (hit)
                begin
                    s1_valid_next        = !muted_reg;
                    s1_op_next.prev_i    = prev_i_reg;
                    s1_op_next.prev_q    = prev_q_reg;
                    s1_op_next.cur_i     = sample.in_i_byte;
                    s1_op_next.cur_q     = sample.in_q_byte;
                    s1_op_next.frac      = acc_reg[iqbr_pkg::FRAC_BITS-1:0];
                    s1_op_next.block_end = (oidx_reg == iqbr_pkg::LAST_OUT_INDEX);
                    oidx_next            = oidx_reg + 1'b1;
                    acc_next             = acc_reg
                                           + {{(iqbr_pkg::ACC_BITS-iqbr_pkg::POS_BITS){1'b0}},
                                              len_reg};
                end
                prev_i_next = sample.in_i_byte;
                prev_q_next = sample.in_q_byte;
                pos_next    = pos_inc;
                // last input of the block becomes sample zero of the next one
                if (block_done)
                begin
                    skip_left_next = skip_after;
                    pos_next       = '0;
                    oidx_next      = '0;
                    acc_next       = '0;
                    muted_next     = (skip_after != '0);
                end
            end
        end
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bypass_reg     <= 1'b0;
            len_reg        <= iqbr_pkg::RESET_BLOCK_LEN;
            have_first_reg <= 1'b0;
            pos_reg        <= '0;
            oidx_reg       <= '0;
            acc_reg        <= '0;
            prev_i_reg     <= '0;
            prev_q_reg     <= '0;
            skip_left_reg  <= '0;
            muted_reg      <= 1'b0;
            s1_valid_reg   <= 1'b0;
        end
        else
        begin
            bypass_reg     <= bypass_next;
            len_reg        <= len_next;
            have_first_reg <= have_first_next;
            pos_reg        <= pos_next;
            oidx_reg       <= oidx_next;
            acc_reg        <= acc_next;
            prev_i_reg     <= prev_i_next;
            prev_q_reg     <= prev_q_next;
            skip_left_reg  <= skip_left_next;
            muted_reg      <= muted_next;
            s1_valid_reg   <= s1_valid_next;
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        s1_op_reg <= s1_op_next;
    end

    // interpolation and result register
    iqbr_interp u_interp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_valid (s1_valid_reg),
        .op_ready (op_ready),
        .op       (s1_op_reg),
        .result   (result)
    );

`ifndef ASSERT_OFF
    // position within a block stays below the block length
    assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg < len_reg)
        else $error("input position reached block length");

    // the pending output never lies behind the current input position
    assert property (@(posedge clk) disable iff (!rst_n)
        acc_reg[iqbr_pkg::ACC_BITS-1:iqbr_pkg::FRAC_BITS] >= pos_reg)
        else $error("pending output fell behind input position");

    // a stage operand is not lost while the output stage is full
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !op_ready |=> s1_valid_reg)
        else $error("stalled operand dropped");

    // the skip counter only grows through a configuration write
    assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_we |=> skip_left_reg <= $past(skip_left_reg))
        else $error("skip counter grew without a write");
`endif

endmodule

`default_nettype wire

>>> hdl/iqbr_interp.sv
// output stage: linear interpolation of i and q into the result register
`default_nettype none

module iqbr_interp
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 op_valid,
    output logic                      op_ready,
    input  wire iqbr_pkg::interp_op_t op,
    iqbr_result_if.source             result
);

    localparam int DIFF_BITS = iqbr_pkg::BYTE_BITS + 1;
    localparam int PROD_BITS = DIFF_BITS + iqbr_pkg::FRAC_BITS + 1;

    logic signed [iqbr_pkg::BYTE_BITS-1:0]   sp_i, sp_q, sc_i, sc_q;
    logic signed [DIFF_BITS-1:0]             diff_i, diff_q;
    logic signed [iqbr_pkg::FRAC_BITS:0]     frac_s;
    logic signed [PROD_BITS-1:0]             sum_i, sum_q;

    logic                                    valid_reg;
    logic signed [iqbr_pkg::OUT_BITS-1:0]    out_i_reg, out_q_reg;
    logic                                    block_end_reg;

    // x_prev*(2048-f) + x_cur*f rewritten as x_prev*2048 + (x_cur-x_prev)*f
    always_comb
    begin
        sp_i   = iqbr_pkg::centered(op.prev_i);
        sp_q   = iqbr_pkg::centered(op.prev_q);
        sc_i   = iqbr_pkg::centered(op.cur_i);
        sc_q   = iqbr_pkg::centered(op.cur_q);
        diff_i = DIFF_BITS'(sc_i) - DIFF_BITS'(sp_i);
        diff_q = DIFF_BITS'(sc_q) - DIFF_BITS'(sp_q);
        frac_s = $signed({1'b0, op.frac});
        sum_i  = (PROD_BITS'(sp_i) <<< iqbr_pkg::FRAC_BITS)
                 + PROD_BITS'(diff_i) * PROD_BITS'(frac_s);
        sum_q  = (PROD_BITS'(sp_q) <<< iqbr_pkg::FRAC_BITS)
                 + PROD_BITS'(diff_q) * PROD_BITS'(frac_s);
    end

    // result register takes a new operand whenever it is empty or being drained
    assign op_ready = !valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (op_valid && op_ready)
        begin
            valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (op_valid && op_ready)
        begin
            out_i_reg     <= sum_i[iqbr_pkg::OUT_BITS-1:0];
            out_q_reg     <= sum_q[iqbr_pkg::OUT_BITS-1:0];
            block_end_reg <= op.block_end;
        end
    end

    assign result.valid     = valid_reg;
    assign result.out_i     = out_i_reg;
    assign result.out_q     = out_q_reg;
    assign result.block_end = block_end_reg;

endmodule

`default_nettype wire
